// ----- hw/rtl/kwsc_pkg.sv -----
`default_nettype none
package kwsc_pkg;

   localparam int unsigned NUM_LETTERS = 26;
   localparam int unsigned LETTER_W = 5;

   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CASE_BIT = 8'h20;

   localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(NUM_LETTERS - 1);
   localparam logic [LETTER_W-1:0] FULL_COUNT = LETTER_W'(NUM_LETTERS);

   localparam logic OP_KEYWORD = 1'b0;
   localparam logic OP_TEXT = 1'b1;

   typedef struct packed {
      logic                is_text;
      logic                is_letter;
      logic                key_last;
      logic                lower;
      logic [LETTER_W-1:0] letter;
      logic [7:0]          raw;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_READ,
      ST_SEND
   } back_state_type;

endpackage
`default_nettype wire

// ----- hw/rtl/keyword_substitution_cipher.sv -----
`default_nettype none
// channel   direction  handshake          payload
// req       in         req_valid/stall    req_op, req_data_byte, req_key_last
// rsp       out        rsp_valid/stall    rsp_out_byte
// csr       in         csr_wr_en          csr_wr_data (decrypt mode)
//
// a keyword word is handled in ST_IDLE in the back end; a finishing keyword word then walks ST_FILL
// a text letter goes ST_IDLE, ST_READ (table read), then ST_SEND (output register), other text skips ST_READ;
// text passes through ST_FILL first if it has to finish the alphabet, walking one letter per cycle
// synchronous active-high reset; no clearing pass, tables are written before read
// the front stage and queue keep taking words while the back end walks or rsp stalls, until the queue is full
module keyword_substitution_cipher #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_op,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_key_last,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   input  wire logic       csr_wr_en,
   input  wire logic       csr_wr_data
);
   import kwsc_pkg::*;

   logic    decrypt_mode_ff;
   logic    push_valid;
   cmd_type push_cmd;
   logic    queue_full;
   logic    head_valid;
   cmd_type head_cmd;
   logic    pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         decrypt_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         decrypt_mode_ff <= csr_wr_data;
      end
   end

   kwsc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_data_byte (req_data_byte),
      .req_key_last  (req_key_last),
      .push_valid    (push_valid),
      .push_cmd      (push_cmd),
      .queue_full    (queue_full)
   );

   kwsc_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop)
   );

   kwsc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .decrypt_mode (decrypt_mode_ff),
      .head_valid   (head_valid),
      .head_cmd     (head_cmd),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte)
   );

endmodule
`default_nettype wire

// ----- hw/rtl/kwsc_front.sv -----
`default_nettype none
module kwsc_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic             req_op,
   input  wire logic [7:0]       req_data_byte,
   input  wire logic             req_key_last,
   output logic                  push_valid,
   output kwsc_pkg::cmd_type     push_cmd,
   input  wire logic             queue_full
);
   import kwsc_pkg::*;

   logic    stage_vld_ff, stage_vld_in;
   cmd_type stage_cmd_ff, stage_cmd_in;
   logic    accept;
   logic    push;
   logic [7:0] folded;
   logic [7:0] offset;

   // fold case and classify the incoming word
   always_comb begin
      folded = req_data_byte | CASE_BIT;
      offset = folded - CHAR_LOWER_A;
      stage_cmd_in.is_text = (req_op == OP_TEXT);
      stage_cmd_in.is_letter = folded inside {[CHAR_LOWER_A:CHAR_LOWER_Z]};
      stage_cmd_in.key_last = req_key_last;
      stage_cmd_in.lower = (req_data_byte >= CHAR_LOWER_A);
      stage_cmd_in.letter = stage_cmd_in.is_letter ? offset[LETTER_W-1:0] : '0;
      stage_cmd_in.raw = req_data_byte;
   end

   assign push = stage_vld_ff && !queue_full;
   assign req_stall = stage_vld_ff && queue_full;
   assign accept = req_valid && !req_stall;
   assign stage_vld_in = accept ? 1'b1 : (push ? 1'b0 : stage_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
      end else begin
         stage_vld_ff <= stage_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_cmd_ff <= stage_cmd_in;
      end
   end

   assign push_valid = push;
   assign push_cmd = stage_cmd_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/kwsc_fifo.sv -----
`default_nettype none
module kwsc_fifo #(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  kwsc_pkg::cmd_type     push_cmd,
   output logic                  full,
   output logic                  head_valid,
   output kwsc_pkg::cmd_type     head_cmd,
   input  wire logic             pop
);
   import kwsc_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   cmd_type            slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd = slots_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/kwsc_back.sv -----
`default_nettype none
module kwsc_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             decrypt_mode,
   input  wire logic             head_valid,
   input  kwsc_pkg::cmd_type     head_cmd,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [7:0]            rsp_out_byte
);
   import kwsc_pkg::*;

   back_state_type state_ff, state_in;

   logic [NUM_LETTERS-1:0] used_ff, used_in;
   logic [LETTER_W-1:0]    fill_ff, fill_in;
   logic                   key_ready_ff, key_ready_in;
   logic [LETTER_W-1:0]    walk_ff, walk_in;
   cmd_type                cur_ff, cur_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_byte_ff, rsp_byte_in;

   logic [LETTER_W-1:0]    fwd_table [NUM_LETTERS];
   logic [LETTER_W-1:0]    inv_table [NUM_LETTERS];
   logic [LETTER_W-1:0]    fwd_rd_ff;
   logic [LETTER_W-1:0]    inv_rd_ff;

   logic [NUM_LETTERS-1:0] used_base;
   logic [LETTER_W-1:0]    fill_base;
   logic [LETTER_W-1:0]    app_letter;
   logic                   app_ok;
   logic                   out_free;
   logic                   load_out;
   logic [LETTER_W-1:0]    mapped;
   logic [7:0]             case_base;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               if (!head_cmd.is_text) begin
                  state_in = head_cmd.key_last ? ST_FILL : ST_IDLE;
               end else if (!key_ready_ff) begin
                  state_in = ST_FILL;
               end else if (head_cmd.is_letter) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_SEND;
               end
            end
         end
         ST_FILL: begin
            if (walk_ff == '0) begin
               if (!cur_ff.is_text) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = cur_ff.is_letter ? ST_READ : ST_SEND;
               end
            end
         end
         ST_READ: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and datapath control
   always_comb begin
      pop = 1'b0;
      load_out = 1'b0;
      used_base = used_ff;
      fill_base = fill_ff;
      app_letter = walk_ff;
      app_ok = 1'b0;
      key_ready_in = key_ready_ff;
      walk_in = walk_ff;
      cur_in = cur_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               cur_in = head_cmd;
               walk_in = LAST_LETTER;
               if (!head_cmd.is_text) begin
                  // a keyword word after a finished key starts over
                  if (key_ready_ff) begin
                     used_base = '0;
                     fill_base = '0;
                  end
                  key_ready_in = 1'b0;
                  app_letter = head_cmd.letter;
                  app_ok = head_cmd.is_letter && !used_base[head_cmd.letter] &&
                           (fill_base < FULL_COUNT);
               end
            end
         end
         ST_FILL: begin
            app_letter = walk_ff;
            app_ok = !used_ff[walk_ff] && (fill_ff < FULL_COUNT);
            walk_in = walk_ff - 1'b1;
            if (walk_ff == '0) begin
               key_ready_in = 1'b1;
            end
         end
         ST_READ: begin
         end
         ST_SEND: begin
            load_out = out_free;
         end
         default: begin
         end
      endcase
      used_in = used_base;
      fill_in = fill_base;
      if (app_ok) begin
         used_in[app_letter] = 1'b1;
         fill_in = fill_base + 1'b1;
      end
   end

   assign mapped = decrypt_mode ? inv_rd_ff : fwd_rd_ff;
   assign case_base = cur_ff.lower ? CHAR_LOWER_A : CHAR_UPPER_A;
   assign rsp_byte_in = cur_ff.is_letter ? (case_base + {3'b000, mapped}) : cur_ff.raw;
   assign rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff <= '0;
         fill_ff <= '0;
         key_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         fill_ff <= fill_in;
         key_ready_ff <= key_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff <= walk_in;
      cur_ff <= cur_in;
      if (load_out) begin
         rsp_byte_ff <= rsp_byte_in;
      end
   end

   // alphabet tables
   always_ff @(posedge clock) begin
      if (app_ok) begin
         fwd_table[fill_base] <= app_letter;
         inv_table[app_letter] <= fill_base;
      end
   end

   always_ff @(posedge clock) begin
      fwd_rd_ff <= fwd_table[cur_ff.letter];
      inv_rd_ff <= inv_table[cur_ff.letter];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;

endmodule
`default_nettype wire

// ----- tb/keyword_substitution_cipher_tb.sv -----
`default_nettype none
module keyword_substitution_cipher_tb;
   import kwsc_pkg::*;

   localparam int unsigned PHASE_WORDS = 210;
   localparam int unsigned NUM_PHASES = 6;
   localparam int unsigned SETTLE_CYCLES = 200;
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned LONG_HOLD = 300;
   localparam int unsigned HOLD_AT = 350;

   typedef struct packed {
      logic       op;
      logic [7:0] data;
      logic       last;
   } cipher_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_op = OP_KEYWORD;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_key_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       csr_wr_en = 1'b0;
   logic       csr_wr_data = 1'b0;

   cipher_word_type pending_words[$];
   logic [7:0]      expected_bytes[$];

   // predictor state
   logic [NUM_LETTERS-1:0] letters_taken = '0;
   logic [LETTER_W-1:0]    plain_to_cipher [NUM_LETTERS];
   logic [LETTER_W-1:0]    cipher_to_plain [NUM_LETTERS];
   logic [LETTER_W-1:0]    alphabet_len = '0;
   logic                   alphabet_done = 1'b0;
   logic                   decrypt_on = 1'b0;

   int unsigned error_count = 0;
   int unsigned keyword_words = 0;
   int unsigned text_words = 0;
   int unsigned words_sent = 0;
   int unsigned results_checked = 0;
   int unsigned idle_cycles = 0;
   logic        hold_request = 1'b0;
   logic        receiver_holding = 1'b0;

   keyword_substitution_cipher u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_data_byte (req_data_byte),
      .req_key_last  (req_key_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic void add_letter(int unsigned idx);
      if (idx >= NUM_LETTERS || alphabet_len >= FULL_COUNT) return;
      if (letters_taken[idx]) return;
      letters_taken[idx] = 1'b1;
      plain_to_cipher[alphabet_len] = LETTER_W'(idx);
      cipher_to_plain[idx] = alphabet_len;
      alphabet_len = alphabet_len + 1'b1;
   endfunction

   function automatic void finish_alphabet();
      for (int k = NUM_LETTERS - 1; k >= 0; k--) add_letter(k);
      alphabet_done = 1'b1;
   endfunction

   function automatic bit substitute_word(input cipher_word_type w, output logic [7:0] result);
      logic [7:0]          folded;
      int unsigned         idx;
      logic [LETTER_W-1:0] mapped;
      result = w.data;
      folded = w.data | CASE_BIT;
      idx = (folded >= CHAR_LOWER_A && folded <= CHAR_LOWER_Z) ?
            int'(folded - CHAR_LOWER_A) : NUM_LETTERS;
      if (w.op == OP_KEYWORD) begin
         if (alphabet_done) begin
            letters_taken = '0;
            alphabet_len = '0;
            alphabet_done = 1'b0;
         end
         add_letter(idx);
         if (w.last) finish_alphabet();
         return 1'b0;
      end
      if (!alphabet_done) finish_alphabet();
      if (idx < NUM_LETTERS) begin
         mapped = decrypt_on ? cipher_to_plain[idx] : plain_to_cipher[idx];
         result = ((w.data >= CHAR_LOWER_A) ? CHAR_LOWER_A : CHAR_UPPER_A) + 8'(mapped);
      end
      return 1'b1;
   endfunction

   // mostly no gap, some short, a few long, with quiet stretches
   function automatic int unsigned next_gap(ref int unsigned quiet);
      int unsigned r;
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 63) == 0) quiet = $urandom_range(30, 120);
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   task automatic push_word(logic op, logic [7:0] data, logic last);
      cipher_word_type w;
      w.op = op;
      w.data = data;
      w.last = last;
      pending_words.push_back(w);
   endtask

   function automatic logic [7:0] random_byte();
      if ($urandom_range(0, 99) < 70)
         return ($urandom_range(0, 1) ? CHAR_UPPER_A : CHAR_LOWER_A) + 8'($urandom_range(0, 25));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] non_letter();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while ((b | CASE_BIT) >= CHAR_LOWER_A && (b | CASE_BIT) <= CHAR_LOWER_Z);
      return b;
   endfunction

   function automatic int unsigned key_length();
      if ($urandom_range(0, 15) == 0) return $urandom_range(20, 34);
      return $urandom_range(1, 10);
   endfunction

   task automatic queue_keyword(int unsigned len, logic finish);
      if (len == 0) begin
         push_word(OP_KEYWORD, non_letter(), finish);
         return;
      end
      for (int unsigned i = 0; i < len; i++)
         push_word(OP_KEYWORD, random_byte(), finish && (i == len - 1));
   endtask

   task automatic queue_text(int unsigned len);
      for (int unsigned i = 0; i < len; i++)
         push_word(OP_TEXT, random_byte(), $urandom_range(0, 7) == 0);
   endtask

   task automatic queue_phase(int unsigned count);
      int unsigned goal;
      int unsigned r;
      goal = pending_words.size() + count;
      while (pending_words.size() < goal) begin
         r = $urandom_range(0, 9);
         if (r <= 6) begin
            if ($urandom_range(0, 9) == 0) queue_keyword(0, 1'b1);
            else queue_keyword(key_length(), 1'b1);
            queue_text($urandom_range(4, 30));
         end else if (r == 7) begin
            queue_keyword(key_length(), 1'b0);
            queue_text($urandom_range(4, 30));
         end else if (r == 8) begin
            queue_keyword(key_length(), 1'b0);
            queue_keyword(key_length(), 1'b1);
            queue_text($urandom_range(4, 30));
         end else begin
            queue_text($urandom_range(1, 20));
         end
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_bytes.size() != 0);
   endtask

   task automatic write_mode(logic mode);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      decrypt_on = mode;
   endtask

   // driver
   always @(posedge clock) begin : drive_words
      cipher_word_type cur;
      cipher_word_type nxt;
      logic [7:0]      out_byte;
      int unsigned     send_gap;
      int unsigned     send_quiet;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
         send_quiet = 0;
      end else begin
         if (req_valid && !req_stall) begin
            cur.op = req_op;
            cur.data = req_data_byte;
            cur.last = req_key_last;
            if (substitute_word(cur, out_byte)) expected_bytes.push_back(out_byte);
            if (cur.op == OP_TEXT) text_words++;
            else keyword_words++;
            words_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (receiver_holding) send_gap = 0;
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               nxt = pending_words.pop_front();
               req_valid <= 1'b1;
               req_op <= nxt.op;
               req_data_byte <= nxt.data;
               req_key_last <= nxt.last;
               send_gap = next_gap(send_quiet);
            end else begin
               req_valid <= 1'b0;
            end
         end
         hold_request <= (words_sent == HOLD_AT);
      end
   end

   // monitor and receiver stalls
   always @(posedge clock) begin : check_results
      logic [7:0]  want;
      int unsigned hold_left;
      int unsigned recv_wait;
      int unsigned recv_quiet;
      bit          long_hold_done;
      if (reset) begin
         rsp_stall <= 1'b0;
         receiver_holding <= 1'b0;
         hold_left = 0;
         recv_wait = 0;
         recv_quiet = 0;
         long_hold_done = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               $display("%0t: out_byte expected none, got %h", $time, rsp_out_byte);
               error_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want) begin
                  $display("%0t: out_byte expected %h, got %h", $time, want, rsp_out_byte);
                  error_count++;
               end
            end
            results_checked++;
         end
         if (hold_request && !long_hold_done) begin
            long_hold_done = 1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            recv_wait = next_gap(recv_quiet);
         end
         receiver_holding <= (hold_left > 0);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic phase_mode [NUM_PHASES];
      phase_mode = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_mode(1'b0);
      @(negedge clock);
      // text before any keyword, boundary bytes around the letters
      push_word(OP_TEXT, 8'h61, 1'b0);
      push_word(OP_TEXT, 8'h5a, 1'b0);
      push_word(OP_TEXT, 8'h00, 1'b0);
      push_word(OP_TEXT, 8'hff, 1'b0);
      push_word(OP_TEXT, 8'he1, 1'b0);
      push_word(OP_TEXT, 8'h40, 1'b0);
      push_word(OP_TEXT, 8'h5b, 1'b0);
      push_word(OP_TEXT, 8'h60, 1'b0);
      push_word(OP_TEXT, 8'h7b, 1'b0);
      // new keyword after a finished key, with a repeat and a non-letter
      push_word(OP_KEYWORD, 8'h51, 1'b0);
      push_word(OP_KEYWORD, 8'h71, 1'b0);
      push_word(OP_KEYWORD, 8'h33, 1'b0);
      push_word(OP_KEYWORD, 8'h41, 1'b0);
      push_word(OP_KEYWORD, 8'h7a, 1'b1);
      push_word(OP_TEXT, 8'h61, 1'b0);
      push_word(OP_TEXT, 8'h51, 1'b1);
      push_word(OP_TEXT, 8'h6d, 1'b0);
      // empty keyword closed by a non-letter
      push_word(OP_KEYWORD, 8'h21, 1'b1);
      push_word(OP_TEXT, 8'h62, 1'b0);
      // unfinished keyword completed by text
      push_word(OP_KEYWORD, 8'h6b, 1'b0);
      push_word(OP_TEXT, 8'h6b, 1'b0);
      push_word(OP_TEXT, 8'h7a, 1'b0);
      for (int unsigned p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         repeat (SETTLE_CYCLES) @(posedge clock);
         write_mode(phase_mode[p]);
         @(negedge clock);
         queue_phase(PHASE_WORDS);
      end
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      $display("sent %0d keyword words and %0d text words over %0d mode settings",
               keyword_words, text_words, NUM_PHASES + 1);
      $display("checked %0d result words in encrypt and decrypt modes", results_checked);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
`default_nettype wire
